/* rtl/core/fbc_pkg.sv */
`default_nettype none

package fbc_pkg;

    localparam int unsigned IDX_W  = 3;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned NWORDS = 4;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_DECRYPT_MODE    = 3'd0;
    localparam reg_idx_t REG_INITIAL_KEY     = 3'd1;
    localparam reg_idx_t REG_FEEDBACK_OFFSET = 3'd2;
    localparam reg_idx_t REG_KEY_WORD0       = 3'd3;
    localparam reg_idx_t REG_KEY_WORD1       = 3'd4;
    localparam reg_idx_t REG_KEY_WORD2       = 3'd5;
    localparam reg_idx_t REG_KEY_WORD3       = 3'd6;

    localparam logic              RST_DECRYPT_MODE    = 1'b0;
    localparam logic [BYTE_W-1:0] RST_INITIAL_KEY     = 8'h5E;
    localparam logic [BYTE_W-1:0] RST_FEEDBACK_OFFSET = 8'h3D;
    localparam logic [DATA_W-1:0] RST_KEY_WORD0       = 32'hF652_73D1;
    localparam logic [DATA_W-1:0] RST_KEY_WORD1       = 32'h27CB_9AD2;
    localparam logic [DATA_W-1:0] RST_KEY_WORD2       = 32'h3159_AF3E;
    localparam logic [DATA_W-1:0] RST_KEY_WORD3       = 32'hA2E7_B337;

    typedef logic [NWORDS-1:0][DATA_W-1:0] key_words_t;

    typedef struct packed {
        logic              decrypt_mode;
        logic [BYTE_W-1:0] initial_key;
        logic [BYTE_W-1:0] feedback_offset;
        key_words_t        key_word;
    } cfg_t;

    typedef struct packed {
        logic             advance;
        logic             last;
        logic             at_start;
        logic [POS_W-1:0] position;
    } status_t;

    function automatic logic [BYTE_W-1:0] table_byte(
        input key_words_t       words,
        input logic [POS_W-1:0] pos
    );
        logic [DATA_W-1:0] w;
        w = words[pos[3:2]];
        return w[pos[1:0]*BYTE_W +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/feedback_byte_cipher.sv */
// Byte-stream cipher with ciphertext feedback, one byte per item.
// Input channel s_valid/s_ready carries s_in_byte and s_last_byte; the
// result channel m_valid/m_ready carries m_out_byte and m_out_last.
// Configuration is a write-only port: cfg_wen, cfg_index, cfg_wdata.
// Write it only while no item is in flight.
// An accepted item passes the input register, then the result register, where
// m_valid rises; a result register held by m_ready low stalls the move.
// Throughput: one item per cycle while m_ready stays high; the key and table
// position close their feedback combinationally between the input and
// result registers.
// The last byte of a buffer returns the table position to zero and the key
// to initial_key for the next byte.
// Reset (aresetn low, synchronous) empties both registers, loads the
// default key table, key and offset, and starts a fresh buffer.
// When the receiver holds m_ready low the result register holds its item,
// the input register takes one more item, and s_ready then drops.
`default_nettype none

module feedback_byte_cipher (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wen,
    input  wire fbc_pkg::reg_idx_t          cfg_index,
    input  wire logic [fbc_pkg::DATA_W-1:0] cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [fbc_pkg::BYTE_W-1:0] s_in_byte,
    input  wire logic                       s_last_byte,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [fbc_pkg::BYTE_W-1:0]      m_out_byte,
    output logic                            m_out_last
);

    fbc_pkg::cfg_t    cfg;
    fbc_pkg::status_t status;

    fbc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fbc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .status      (status)
    );

`ifndef ASSERT_OFF
    a_start_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        status.at_start |-> status.position == '0)
        else $error("fresh buffer with nonzero table position");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result register is empty");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        status.advance && !status.last |=>
            status.position == $past(status.position) + 4'd1 && !status.at_start)
        else $error("table position did not advance");

    a_last_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        status.advance && status.last |=> status.at_start)
        else $error("buffer did not restart after last item");
`endif

endmodule

`default_nettype wire

/* rtl/core/fbc_cfg.sv */
`default_nettype none

module fbc_cfg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wen,
    input  wire fbc_pkg::reg_idx_t         cfg_index,
    input  wire logic [fbc_pkg::DATA_W-1:0] cfg_wdata,
    output fbc_pkg::cfg_t                  cfg
);

    fbc_pkg::cfg_t cfg_reg;
    fbc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            case (cfg_index)
                fbc_pkg::REG_DECRYPT_MODE:    cfg_next.decrypt_mode = cfg_wdata[0];
                fbc_pkg::REG_INITIAL_KEY:     cfg_next.initial_key = cfg_wdata[7:0];
                fbc_pkg::REG_FEEDBACK_OFFSET: cfg_next.feedback_offset = cfg_wdata[7:0];
                fbc_pkg::REG_KEY_WORD0:       cfg_next.key_word[0] = cfg_wdata;
                fbc_pkg::REG_KEY_WORD1:       cfg_next.key_word[1] = cfg_wdata;
                fbc_pkg::REG_KEY_WORD2:       cfg_next.key_word[2] = cfg_wdata;
                fbc_pkg::REG_KEY_WORD3:       cfg_next.key_word[3] = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.decrypt_mode    <= fbc_pkg::RST_DECRYPT_MODE;
            cfg_reg.initial_key     <= fbc_pkg::RST_INITIAL_KEY;
            cfg_reg.feedback_offset <= fbc_pkg::RST_FEEDBACK_OFFSET;
            cfg_reg.key_word[0]     <= fbc_pkg::RST_KEY_WORD0;
            cfg_reg.key_word[1]     <= fbc_pkg::RST_KEY_WORD1;
            cfg_reg.key_word[2]     <= fbc_pkg::RST_KEY_WORD2;
            cfg_reg.key_word[3]     <= fbc_pkg::RST_KEY_WORD3;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/fbc_core.sv */
`default_nettype none

module fbc_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire fbc_pkg::cfg_t              cfg,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [fbc_pkg::BYTE_W-1:0] s_in_byte,
    input  wire logic                       s_last_byte,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [fbc_pkg::BYTE_W-1:0]      m_out_byte,
    output logic                            m_out_last,
    output fbc_pkg::status_t                status
);

    logic                        in_valid_reg, in_valid_next;
    logic [fbc_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        in_last_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [fbc_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                        out_last_reg;

    logic                        at_start_reg, at_start_next;
    logic [fbc_pkg::POS_W-1:0]   position_reg, position_next;
    logic [fbc_pkg::BYTE_W-1:0]  feedback_key_reg, feedback_key_next;

    logic                        in_take;
    logic                        advance;
    logic [fbc_pkg::BYTE_W-1:0]  key;
    logic [fbc_pkg::BYTE_W-1:0]  pad;
    logic [fbc_pkg::BYTE_W-1:0]  enc_byte;
    logic [fbc_pkg::BYTE_W-1:0]  dec_byte;
    logic [fbc_pkg::BYTE_W-1:0]  result;
    logic [fbc_pkg::BYTE_W-1:0]  cipher;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_comb begin
        key      = at_start_reg ? cfg.initial_key : feedback_key_reg;
        pad      = fbc_pkg::table_byte(cfg.key_word, position_reg);
        enc_byte = (in_byte_reg + key) ^ pad;
        dec_byte = (in_byte_reg ^ pad) - key;
        result   = cfg.decrypt_mode ? dec_byte : enc_byte;
        cipher   = cfg.decrypt_mode ? in_byte_reg : enc_byte;

        at_start_next     = at_start_reg;
        position_next     = position_reg;
        feedback_key_next = feedback_key_reg;
        if (advance) begin
            if (in_last_reg) begin
                at_start_next     = 1'b1;
                position_next     = '0;
                feedback_key_next = cfg.initial_key;
            end else begin
                at_start_next     = 1'b0;
                position_next     = position_reg + 1'b1;
                feedback_key_next = cipher + cfg.feedback_offset;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            at_start_reg  <= 1'b1;
            position_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            at_start_reg  <= at_start_next;
            position_reg  <= position_next;
        end
    end

    always_ff @(posedge aclk) begin
        feedback_key_reg <= feedback_key_next;
        if (in_take) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_last_byte;
        end
        if (advance) begin
            out_byte_reg <= result;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_out_last = out_last_reg;

    assign status.advance  = advance;
    assign status.last     = in_last_reg;
    assign status.at_start = at_start_reg;
    assign status.position = position_reg;

endmodule

`default_nettype wire
